/* rtl/assert_macros.svh */
// Assertion macros shared by checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define CHK_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/ohm_pkg.sv */
// ----------------------------------------------------------------------------
// ohm_pkg
// Types and constants of the open addressing hash map.
// ----------------------------------------------------------------------------
package ohm_pkg;
    localparam logic [63:0] HASH_BASIS = 64'hcbf29ce484222325;
    localparam logic [63:0] HASH_PRIME = 64'h00000100000001b3;
    localparam int unsigned CNT_W = 10;
    localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 10'd717;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_LOOKUP = 2'd0;
    localparam t_cmd CMD_INSERT = 2'd1;
    localparam t_cmd CMD_RANK   = 2'd2;

    typedef logic [2:0] t_status;
    localparam t_status ST_HIT   = 3'd0;
    localparam t_status ST_MISS  = 3'd1;
    localparam t_status ST_NEW   = 3'd2;
    localparam t_status ST_OVER  = 3'd3;
    localparam t_status ST_FULL  = 3'd4;
    localparam t_status ST_RANGE = 3'd5;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_hash_ctl;
endpackage

/* rtl/open_addressing_hash_map.sv */
// ----------------------------------------------------------------------------
// open_addressing_hash_map
// Linear probing hash map, three-word keys, four-word values, in slot memories.
// ----------------------------------------------------------------------------
// Lookup/insert: the key is hashed, then each probed slot is read and checked, then the result is output.
// Read by rank: slots are read and checked in order from slot 0 up to the hit, then the result is output.
// Throughput: one command at a time, busy high until the result strobe.
// The hash unit's serial multiply and the slot memory read port set the rate.
// Reset: synchronous; the used bits of all slots are then cleared in turn (busy high).
// Results cannot be stalled; each is shown for one cycle on o_done.
module open_addressing_hash_map #(
    parameter int unsigned CAPACITY = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_cfg_we,
    input  logic [9:0]           i_cfg_wdata,
    input  ohm_pkg::t_cmd        i_command,
    input  logic [63:0]          i_key_a,
    input  logic [63:0]          i_key_b,
    input  logic [63:0]          i_key_c,
    input  logic [63:0]          i_value_r1,
    input  logic [63:0]          i_value_t1,
    input  logic [63:0]          i_value_ru,
    input  logic [63:0]          i_value_tu,
    input  logic [9:0]           i_rank,
    output logic                 o_done,
    output ohm_pkg::t_status     o_status,
    output logic [63:0]          o_out_key_a,
    output logic [63:0]          o_out_key_b,
    output logic [63:0]          o_out_key_c,
    output logic [63:0]          o_out_r1,
    output logic [63:0]          o_out_t1,
    output logic [63:0]          o_out_ru,
    output logic [63:0]          o_out_tu,
    output logic [9:0]           o_entry_total
);
    import ohm_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_HASH = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    typedef struct packed {
        logic          used;
        logic [63:0]   hash;
        logic [191:0]  keys;
        logic [255:0]  vals;
    } t_slot;

    t_slot mem [CAPACITY];
    t_slot r_rd;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_pos, n_pos;
    logic [AW:0]   r_cnt, n_cnt;
    logic [9:0]    r_seen, n_seen;
    logic [9:0]    r_max;
    logic [9:0]    r_count, n_count;
    t_cmd          r_cmd;
    logic [191:0]  r_key;
    logic [255:0]  r_val;
    logic [9:0]    r_rank;
    logic [63:0]   r_h, n_h;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_slot         w_wdata;
    logic          r_done, n_done;
    t_status       r_status, n_status;
    logic [191:0]  r_okey, n_okey;
    logic [255:0]  r_oval, n_oval;
    logic          w_hstart, w_hdone;
    logic [63:0]   w_hash;
    logic [9:0]    w_limit;
    logic          w_match;

    ohm_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hstart),
        .i_key_a (r_key[191:128]),
        .i_key_b (r_key[127:64]),
        .i_key_c (r_key[63:0]),
        .o_done  (w_hdone),
        .o_hash  (w_hash)
    );

    always_comb begin
        if (CAPACITY - 1 < 1023 && 32'(r_max) > CAPACITY - 1) begin
            w_limit = 10'(CAPACITY - 1);
        end else begin
            w_limit = r_max;
        end
    end

    assign w_match = r_rd.hash == r_h && r_rd.keys == r_key;
    assign w_hstart = r_state == S_HASH && r_cnt == '0;

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_cnt    = r_cnt;
        n_seen   = r_seen;
        n_count  = r_count;
        n_h      = r_h;
        n_done   = 1'b0;
        n_status = r_status;
        n_okey   = r_okey;
        n_oval   = r_oval;
        w_we     = 1'b0;
        w_waddr  = r_pos;
        w_wdata  = '{used: 1'b1, hash: r_h, keys: r_key, vals: r_val};
        case (r_state)
            S_CLR: begin
                w_we    = 1'b1;
                w_wdata = '0;
                n_pos   = r_pos + 1'b1;
                if (r_pos == AW'(CAPACITY - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_cnt    = '0;
                    n_seen   = '0;
                    n_okey   = '0;
                    n_oval   = '0;
                    n_status = ST_MISS;
                    if (i_command == CMD_LOOKUP || i_command == CMD_INSERT) begin
                        n_state = S_HASH;
                    end else if (i_command == CMD_RANK && i_rank < r_count) begin
                        n_pos   = '0;
                        n_state = S_RD;
                    end else begin
                        if (i_command == CMD_RANK) begin
                            n_status = ST_RANGE;
                        end
                        n_state = S_OUT;
                    end
                end
            end
            S_HASH: begin
                n_cnt = {{AW{1'b0}}, 1'b1};
                if (w_hdone) begin
                    n_h     = w_hash;
                    n_pos   = w_hash[AW-1:0];
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                n_state = S_RD;
                n_pos   = r_pos + 1'b1;
                if (r_cmd == CMD_RANK) begin
                    if (r_rd.used) begin
                        if (r_seen == r_rank) begin
                            n_status = ST_HIT;
                            n_okey   = r_rd.keys;
                            n_oval   = r_rd.vals;
                            n_state  = S_OUT;
                        end
                        n_seen = r_seen + 10'd1;
                    end
                end else if (!r_rd.used) begin
                    n_state = S_OUT;
                    if (r_cmd == CMD_INSERT) begin
                        if (r_count >= w_limit) begin
                            n_status = ST_FULL;
                        end else begin
                            w_we     = 1'b1;
                            n_count  = r_count + 10'd1;
                            n_status = ST_NEW;
                        end
                    end
                end else if (w_match) begin
                    n_state = S_OUT;
                    if (r_cmd == CMD_INSERT) begin
                        w_we         = 1'b1;
                        w_wdata.hash = r_rd.hash;
                        n_status     = ST_OVER;
                    end else begin
                        n_status = ST_HIT;
                        n_oval   = r_rd.vals;
                    end
                end
            end
            S_OUT: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd <= mem[n_pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_pos   <= '0;
            r_count <= '0;
            r_max   <= MAX_ENTRIES_RST;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_count <= n_count;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
        end
        r_cnt    <= n_cnt;
        r_seen   <= n_seen;
        r_h      <= n_h;
        r_status <= n_status;
        r_okey   <= n_okey;
        r_oval   <= n_oval;
        if (r_state == S_IDLE && start) begin
            r_cmd  <= i_command;
            r_key  <= {i_key_a, i_key_b, i_key_c};
            r_val  <= {i_value_r1, i_value_t1, i_value_ru, i_value_tu};
            r_rank <= i_rank;
        end
    end

    assign busy          = r_state != S_IDLE;
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_out_key_a   = r_okey[191:128];
    assign o_out_key_b   = r_okey[127:64];
    assign o_out_key_c   = r_okey[63:0];
    assign o_out_r1      = r_oval[255:192];
    assign o_out_t1      = r_oval[191:128];
    assign o_out_ru      = r_oval[127:64];
    assign o_out_tu      = r_oval[63:0];
    assign o_entry_total = r_count;
endmodule

/* rtl/ohm_hash.sv */
// ----------------------------------------------------------------------------
// ohm_hash
// FNV-1a over three 64-bit words, one word at a time; each 64x64 multiply is three
// 32x32 partial products, formed in turn after the word is XORed in.
// ----------------------------------------------------------------------------
module ohm_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_key_a,
    input  logic [63:0] i_key_b,
    input  logic [63:0] i_key_c,
    output logic        o_done,
    output logic [63:0] o_hash
);
    import ohm_pkg::*;

    logic        r_busy, n_busy;
    logic [1:0]  r_word, n_word;
    logic [1:0]  r_part, n_part;
    logic [63:0] r_x, n_x;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_h, n_h;
    logic        r_done, n_done;
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_prod;
    logic [63:0] w_word;

    always_comb begin
        case (r_word)
            2'd0:    w_word = i_key_a;
            2'd1:    w_word = i_key_b;
            default: w_word = i_key_c;
        endcase
    end

    // partials: lo*lo, lo*hi, hi*lo (hi*hi drops out mod 2^64)
    always_comb begin
        case (r_part)
            2'd0:    begin w_ma = r_x[31:0];  w_mb = HASH_PRIME[31:0];  end
            2'd1:    begin w_ma = r_x[31:0];  w_mb = HASH_PRIME[63:32]; end
            default: begin w_ma = r_x[63:32]; w_mb = HASH_PRIME[31:0];  end
        endcase
    end
    assign w_prod = 64'(w_ma) * 64'(w_mb);

    always_comb begin
        n_busy = r_busy;
        n_word = r_word;
        n_part = r_part;
        n_x    = r_x;
        n_acc  = r_acc;
        n_h    = r_h;
        n_done = 1'b0;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_word = 2'd0;
                n_part = 2'd3;
                n_h    = HASH_BASIS;
            end
        end else begin
            case (r_part)
                2'd3: begin
                    n_x    = r_h ^ w_word;
                    n_acc  = '0;
                    n_part = 2'd0;
                end
                2'd0: begin
                    n_acc  = w_prod;
                    n_part = 2'd1;
                end
                2'd1: begin
                    n_acc  = r_acc + {w_prod[31:0], 32'd0};
                    n_part = 2'd2;
                end
                default: begin
                    n_h    = r_acc + {w_prod[31:0], 32'd0};
                    n_part = 2'd3;
                    if (r_word == 2'd2) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end else begin
                        n_word = r_word + 2'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_word <= n_word;
        r_part <= n_part;
        r_x    <= n_x;
        r_acc  <= n_acc;
        r_h    <= n_h;
    end

    assign o_done = r_done;
    assign o_hash = r_h;
endmodule

/* rtl/ohm_checker.sv */
// ----------------------------------------------------------------------------
// ohm_checker
// Port-level checks of the hash map, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ohm_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_done,
    input ohm_pkg::t_status o_status,
    input logic [9:0]       o_entry_total,
    input logic [63:0]      o_out_key_a
);
    import ohm_pkg::*;

    `CHK_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "no busy after accept")
    `CHK_IMPL(a_done_busy, i_clk, i_rst_n, o_done, !busy, "result while still busy")
    `CHK_IMPL(a_status_range, i_clk, i_rst_n, o_done, o_status <= ST_RANGE, "bad status")
    `CHK_IMPL(a_key_zero, i_clk, i_rst_n, o_done && o_status != ST_HIT,
        o_out_key_a == 64'd0, "key words set without hit")
    `CHK_NEXT(a_total_mono, i_clk, i_rst_n, 1'b1,
        o_entry_total >= $past(o_entry_total), "entry total fell")
endmodule

bind open_addressing_hash_map ohm_checker u_ohm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_status      (o_status),
    .o_entry_total (o_entry_total),
    .o_out_key_a   (o_out_key_a)
);
